### design/drq_pkg.sv
// shared constants, codes and types for the disk request queue (sstf)
// no dependencies; imported by the interfaces, the cells, the min tree and the top level
`default_nettype none

package drq_pkg;

    localparam int DEPTH   = 64;
    localparam int CYL_W   = 16;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W   = CYL_W + 1;
    localparam int CMD_W   = 3;

    // request opcodes
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_OLDEST  = 3'd1;
    localparam logic [OP_W-1:0] OP_NEWEST  = 3'd2;
    localparam logic [OP_W-1:0] OP_NEAREST = 3'd3;
    localparam logic [OP_W-1:0] OP_MATCH   = 3'd4;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // commands broadcast to the cell row
    localparam logic [CMD_W-1:0] CMD_HOLD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MARK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BUBBLE = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] pos;
        logic [CYL_W-1:0] cyl;
        logic [CYL_W-1:0] head;
    } drq_cell_ctl_t;

endpackage

`default_nettype wire

### design/drq_req_if.sv
// request channel: valid/ready handshake carrying opcode, cylinder and head position
// depends on drq_pkg
`default_nettype none

interface drq_req_if;
    import drq_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [CYL_W-1:0] cylinder;
    logic [CYL_W-1:0] head_position;

    modport source (output valid, output opcode, output cylinder, output head_position,
                    input ready);
    modport sink   (input valid, input opcode, input cylinder, input head_position,
                    output ready);
endinterface

`default_nettype wire

### design/drq_rsp_if.sv
// response channel: valid/ready handshake carrying status, removed cylinder and counts
// depends on drq_pkg
`default_nettype none

interface drq_rsp_if;
    import drq_pkg::*;

    logic               valid;
    logic               ready;
    logic [ST_W-1:0]    status;
    logic [CYL_W-1:0]   removed_cylinder;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, output status, output removed_cylinder, output hit_count,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input removed_cylinder, input hit_count,
                    input entry_count, output ready);
endinterface

`default_nettype wire

### design/drq_cell.sv
// one slot of the request row: holds a cylinder and its valid bit, shifts with its neighbor
// depends on drq_pkg
`default_nettype none

module drq_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  drq_pkg::drq_cell_ctl_t      ctl,
    input  logic [drq_pkg::IDX_W-1:0]   cell_index,
    input  logic                        left_valid,
    input  logic                        right_valid,
    input  logic [drq_pkg::CYL_W-1:0]   right_value,
    output logic                        valid,
    output logic [drq_pkg::CYL_W-1:0]   value,
    output logic [drq_pkg::KEY_W-1:0]   key
);
    import drq_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [CYL_W-1:0] value_reg;
    logic [CYL_W-1:0] value_next;
    logic [CYL_W-1:0] seek_dist;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        case (ctl.cmd)
            CMD_APPEND:
            begin
                if (cell_index == ctl.pos)
                begin
                    valid_next = 1'b1;
                    value_next = ctl.cyl;
                end
            end
            CMD_REMOVE:
            begin
                // slots at and above the removed one pull from the right
                if (cell_index >= ctl.pos)
                begin
                    valid_next = right_valid;
                    value_next = right_value;
                end
            end
            CMD_MARK:
            begin
                if (valid_reg && (value_reg == ctl.cyl))
                    valid_next = 1'b0;
            end
            CMD_BUBBLE:
            begin
                // a hole takes its right neighbor; an entry over a hole hands itself down
                if (!valid_reg && right_valid)
                begin
                    valid_next = 1'b1;
                    value_next = right_value;
                end
                else if (valid_reg && !left_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_comb
    begin
        if (!valid_reg)
            seek_dist = '1;
        else if (value_reg >= ctl.head)
            seek_dist = value_reg - ctl.head;
        else
            seek_dist = ctl.head - value_reg;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign key   = {!valid_reg, seek_dist};

endmodule

`default_nettype wire

### design/drq_min_tree.sv
// registered minimum tree over the cell distance keys; the lower index wins a tie
// depends on drq_pkg; one register level per tree level
`default_nettype none

module drq_min_tree (
    input  logic                      clk,
    input  logic [drq_pkg::KEY_W-1:0] leaf_key [drq_pkg::DEPTH],
    output logic [drq_pkg::IDX_W-1:0] best_idx
);
    import drq_pkg::*;

    localparam int LEAVES = 1 << IDX_W;

    logic [KEY_W-1:0] pad_key [LEAVES];
    logic [KEY_W-1:0] key_reg [1:2*LEAVES-1];
    logic [IDX_W-1:0] idx_reg [1:2*LEAVES-1];

    for (genvar g = 0; g < LEAVES; g++)
    begin : g_pad
        if (g < DEPTH)
        begin : g_real
            assign pad_key[g] = leaf_key[g];
        end
        else
        begin : g_fill
            assign pad_key[g] = '1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < LEAVES; n++)
        begin
            key_reg[LEAVES + n] <= pad_key[n];
            idx_reg[LEAVES + n] <= IDX_W'(n);
        end
        for (int n = 1; n < LEAVES; n++)
        begin
            if (key_reg[2*n + 1] < key_reg[2*n])
            begin
                key_reg[n] <= key_reg[2*n + 1];
                idx_reg[n] <= idx_reg[2*n + 1];
            end
            else
            begin
                key_reg[n] <= key_reg[2*n];
                idx_reg[n] <= idx_reg[2*n];
            end
        end
    end

    assign best_idx = idx_reg[1];

endmodule

`default_nettype wire

### design/disk_request_queue_sstf_top.sv
// disk request queue with shortest-seek-first removal: control, cell row, min tree, output reg
// depends on drq_pkg, drq_req_if, drq_rsp_if, drq_cell and drq_min_tree

// Requests are held oldest first in a row of DEPTH cells, each holding one cylinder and a
// valid bit and shifting toward slot 0 from its right neighbor. One request beat is taken
// while the controller is idle and gives one response beat. Append, take oldest, take
// newest and unused opcodes pass from accept through the request latch and one cell-row
// update, which also loads the result register, to the response register. Take nearest
// first waits in a search state while the distance keys pass the registered minimum
// tree. Remove-matching clears every match in a mark step and then compacts the row by
// neighbor-to-neighbor moves, one slot per cycle, while a hole lies below a held entry.
// A response waiting in the output register does not stop the next request.
`default_nettype none

module disk_request_queue_sstf_top (
    input  logic      clk,
    input  logic      rst_n,
    drq_req_if.sink   req,
    drq_rsp_if.source rsp
);
    import drq_pkg::*;

    localparam int TREE_LAT = IDX_W + 1;
    localparam int SRCH_W   = $clog2(TREE_LAT + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SEARCH  = 3'd1;
    localparam logic [2:0] S_MARK    = 3'd2;
    localparam logic [2:0] S_COMPACT = 3'd3;
    localparam logic [2:0] S_EXEC    = 3'd4;
    localparam logic [2:0] S_RESULT  = 3'd5;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [SRCH_W-1:0]  search_cnt_reg;
    logic [SRCH_W-1:0]  search_cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [OP_W-1:0]    op_reg;
    logic [CYL_W-1:0]   cyl_reg;
    logic [CYL_W-1:0]   head_reg;

    logic [ST_W-1:0]    res_status_reg;
    logic [ST_W-1:0]    res_status_next;
    logic [CYL_W-1:0]   res_removed_reg;
    logic [CYL_W-1:0]   res_removed_next;
    logic [COUNT_W-1:0] res_hits_reg;
    logic [COUNT_W-1:0] res_hits_next;
    logic [COUNT_W-1:0] res_count_reg;
    logic               res_load;
    logic               load_out;

    logic [ST_W-1:0]    out_status_reg;
    logic [CYL_W-1:0]   out_removed_reg;
    logic [COUNT_W-1:0] out_hits_reg;
    logic [COUNT_W-1:0] out_count_reg;

    drq_cell_ctl_t      ctl;
    logic [IDX_W-1:0]   exec_pos;
    logic [IDX_W-1:0]   best_idx;
    logic [CYL_W-1:0]   sel_value;
    logic [COUNT_W-1:0] valid_count;
    logic [COUNT_W-1:0] hits;
    logic               gap_any;
    logic               accept;

    logic               cell_valid [DEPTH];
    logic [CYL_W-1:0]   cell_value [DEPTH];
    logic [KEY_W-1:0]   cell_key   [DEPTH];

    // cell row
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic             left_v;
        logic             right_v;
        logic [CYL_W-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_v = 1'b1;
        end
        else
        begin : g_mid_l
            assign left_v = cell_valid[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_v = 1'b0;
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_v = cell_valid[g+1];
            assign right_d = cell_value[g+1];
        end

        drq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .cell_index  (IDX_W'(g)),
            .left_valid  (left_v),
            .right_valid (right_v),
            .right_value (right_d),
            .valid       (cell_valid[g]),
            .value       (cell_value[g]),
            .key         (cell_key[g])
        );
    end

    drq_min_tree u_min_tree (
        .clk      (clk),
        .leaf_key (cell_key),
        .best_idx (best_idx)
    );

    // occupancy from the thermometer edge, hole detection and the selected slot's value
    always_comb
    begin
        valid_count = '0;
        gap_any     = 1'b0;
        sel_value   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_valid[i] && ((i == DEPTH - 1) || !cell_valid[(i + 1) % DEPTH]))
                valid_count = valid_count | COUNT_W'(i + 1);
            if ((i < DEPTH - 1) && !cell_valid[i] && cell_valid[(i + 1) % DEPTH])
                gap_any = 1'b1;
            if (IDX_W'(i) == exec_pos)
                sel_value = sel_value | cell_value[i];
        end
    end

    assign hits = count_reg - valid_count;

    always_comb
    begin
        case (op_reg)
            OP_APPEND:  exec_pos = count_reg[IDX_W-1:0];
            OP_NEWEST:  exec_pos = IDX_W'(count_reg - COUNT_W'(1));
            OP_NEAREST: exec_pos = best_idx;
            default:    exec_pos = '0;
        endcase
    end

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        search_cnt_next  = search_cnt_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        load_out         = 1'b0;
        res_load         = 1'b0;
        res_status_next  = ST_OK;
        res_removed_next = '0;
        res_hits_next    = '0;
        ctl.cmd          = CMD_HOLD;
        ctl.pos          = exec_pos;
        ctl.cyl          = cyl_reg;
        ctl.head         = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    search_cnt_next = '0;
                    if (req.opcode == OP_MATCH)
                        state_next = S_MARK;
                    else if ((req.opcode == OP_NEAREST) && (count_reg != '0))
                        state_next = S_SEARCH;
                    else
                        state_next = S_EXEC;
                end
            end
            S_SEARCH:
            begin
                if (search_cnt_reg == SRCH_W'(TREE_LAT))
                    state_next = S_EXEC;
                else
                    search_cnt_next = search_cnt_reg + SRCH_W'(1);
            end
            S_MARK:
            begin
                ctl.cmd    = CMD_MARK;
                state_next = S_COMPACT;
            end
            S_COMPACT:
            begin
                if (gap_any)
                begin
                    ctl.cmd = CMD_BUBBLE;
                end
                else
                begin
                    res_load        = 1'b1;
                    res_hits_next   = hits;
                    res_status_next = (hits == '0) ? ST_EMPTY : ST_OK;
                    count_next      = valid_count;
                    state_next      = S_RESULT;
                end
            end
            S_EXEC:
            begin
                res_load   = 1'b1;
                state_next = S_RESULT;
                if (op_reg == OP_APPEND)
                begin
                    if (count_reg == COUNT_W'(DEPTH))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        ctl.cmd    = CMD_APPEND;
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                else if (op_reg inside {OP_OLDEST, OP_NEWEST, OP_NEAREST})
                begin
                    if (count_reg == '0)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.cmd          = CMD_REMOVE;
                        res_removed_next = sel_value;
                        count_next       = count_reg - COUNT_W'(1);
                    end
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            search_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            search_cnt_reg <= search_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.opcode;
            cyl_reg  <= req.cylinder;
            head_reg <= req.head_position;
        end
        if (res_load)
        begin
            res_status_reg  <= res_status_next;
            res_removed_reg <= res_removed_next;
            res_hits_reg    <= res_hits_next;
            res_count_reg   <= count_next;
        end
        if (load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_removed_reg <= res_removed_reg;
            out_hits_reg    <= res_hits_reg;
            out_count_reg   <= res_count_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.removed_cylinder = out_removed_reg;
    assign rsp.hit_count        = out_hits_reg;
    assign rsp.entry_count      = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("held count above depth");

    a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !gap_any)
        else $error("hole below a held entry while idle");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (count_reg == valid_count))
        else $error("held count disagrees with valid cells");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_FULL)) |-> (rsp.entry_count == COUNT_W'(DEPTH)))
        else $error("full status with room left");

endmodule

`default_nettype wire
